// ===== rtl/core/mcfp_pkg.sv =====
// Package for the motor command frame parser.
// Types, frame characters, reset values and digit arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package mcfp_pkg;

    localparam int VAL_W = 15;

    localparam logic [7:0] CH_WHEEL = 8'h3C;  // '<'
    localparam logic [7:0] CH_ANGLE = 8'h5B;  // '['
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CH_MOVE  = 8'h7E;  // '~'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    localparam logic signed [VAL_W-1:0] ANGLE_HALF = 15'sd180;
    localparam logic signed [VAL_W-1:0] ANGLE_FULL = 15'sd360;

    localparam logic [15:0] IDLE_LIMIT_RST = 16'd100;
    localparam logic        STOP_EN_RST    = 1'b1;
    localparam logic [7:0]  ERR_BUDGET_RST = 8'd20;

    localparam logic [1:0] CFG_IDLE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_STOP_EN    = 2'd1;
    localparam logic [1:0] CFG_ERR_BUDGET = 2'd2;

    typedef enum logic [1:0] {
        RK_WHEEL = 2'd0,
        RK_ANGLE = 2'd1,
        RK_MOVE  = 2'd2,
        RK_STOP  = 2'd3
    } res_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WHEEL,
        PH_ANGLE,
        PH_MOVE,
        PH_BANG
    } phase_t;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic      result_valid;
        res_kind_t result_kind;
        val_t      value_a;
        val_t      value_b;
        val_t      value_c;
        val_t      value_d;
        logic [7:0] move_code;
        logic      stray;
        logic      reload;
    } frame_evt_t;

    // (byte - '0') wrapped to signed 8 bits, then acc*10 + digit
    function automatic val_t push_digit(input val_t base, input logic [7:0] b);
        logic [7:0] d;
        val_t       dext;
        d    = b - CH_ZERO;
        dext = val_t'(signed'(d));
        return (base <<< 3) + (base <<< 1) + dext;
    endfunction

    function automatic val_t fold_angle(input val_t v);
        if (v > ANGLE_HALF)
            return v - ANGLE_FULL;
        else if (v < -ANGLE_HALF)
            return v + ANGLE_FULL;
        else
            return v;
    endfunction

endpackage

// ===== rtl/core/mcfp_frame.sv =====
// Frame parser: phase sequencer, digit accumulator and value store.
// Depends on mcfp_pkg. Reports per-byte events to the top level.
`timescale 1ns / 1ps

module mcfp_frame
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_en,
    input  logic [7:0]         data_byte,
    output mcfp_pkg::frame_evt_t evt
);
    import mcfp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] step_reg, step_next;
    val_t       acc_reg, acc_next;
    logic       neg_reg, neg_next;
    logic [7:0] held_reg, held_next;
    val_t       store_reg [4];
    logic [3:0] store_we;
    val_t       store_wdata;

    logic       first_digit;
    val_t       acc_sum;
    val_t       wheel_val;
    val_t       fold_val;
    logic [1:0] wheel_grp;

    assign wheel_grp = step_reg[3:2];

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    step_next = '0;
                    if (data_byte == CH_WHEEL)
                        phase_next = PH_WHEEL;
                    else if (data_byte == CH_ANGLE)
                        phase_next = PH_ANGLE;
                    else if (data_byte == CH_MOVE)
                        phase_next = PH_MOVE;
                    else if (data_byte == CH_BANG)
                        phase_next = PH_BANG;
                end
                PH_WHEEL:
                begin
                    if (step_reg == 4'd15)
                    begin
                        phase_next = PH_IDLE;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
                PH_ANGLE:
                begin
                    if (step_reg == 4'd5)
                    begin
                        phase_next = PH_IDLE;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
                PH_MOVE:
                begin
                    if (step_reg == 4'd3)
                    begin
                        phase_next = PH_IDLE;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    step_next  = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        first_digit = ((phase_reg == PH_WHEEL) && (step_reg[1:0] == 2'd1))
                   || ((phase_reg == PH_ANGLE) && ((step_reg == 4'd0) || (step_reg == 4'd3)))
                   || ((phase_reg == PH_MOVE) && (step_reg == 4'd1));
        acc_sum   = push_digit(first_digit ? val_t'(0) : acc_reg, data_byte);
        wheel_val = neg_reg ? -acc_sum : acc_sum;
        fold_val  = fold_angle(acc_sum);

        acc_next    = acc_reg;
        neg_next    = neg_reg;
        held_next   = held_reg;
        store_we    = '0;
        store_wdata = (phase_reg == PH_ANGLE) ? fold_val : wheel_val;
        evt         = '0;
        evt.result_kind = RK_WHEEL;

        unique case (phase_reg)
            PH_IDLE:
            begin
                evt.stray = (data_byte != CH_WHEEL) && (data_byte != CH_ANGLE)
                         && (data_byte != CH_MOVE) && (data_byte != CH_BANG);
            end
            PH_WHEEL:
            begin
                if (step_reg[1:0] == 2'd0)
                begin
                    neg_next = (data_byte == CH_MINUS);
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_sum;
                    if (step_reg[1:0] == 2'd3)
                        store_we[wheel_grp] = 1'b1;
                end
                if (step_reg == 4'd15)
                begin
                    evt.result_valid = 1'b1;
                    evt.result_kind  = RK_WHEEL;
                    evt.value_a      = store_reg[0];
                    evt.value_b      = store_reg[1];
                    evt.value_c      = store_reg[2];
                    evt.value_d      = wheel_val;
                end
            end
            PH_ANGLE:
            begin
                acc_next = acc_sum;
                if (step_reg == 4'd2)
                    store_we[0] = 1'b1;
                if (step_reg == 4'd5)
                begin
                    evt.result_valid = 1'b1;
                    evt.result_kind  = RK_ANGLE;
                    evt.value_a      = store_reg[0];
                    evt.value_b      = fold_val;
                end
            end
            PH_MOVE:
            begin
                if (step_reg == 4'd0)
                    held_next = data_byte;
                else
                    acc_next = acc_sum;
                if (step_reg == 4'd3)
                begin
                    evt.result_valid = 1'b1;
                    evt.result_kind  = RK_MOVE;
                    evt.value_a      = acc_sum;
                    evt.move_code    = held_reg;
                    evt.reload       = 1'b1;
                end
            end
            default:
            begin
                evt.reload = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            held_reg  <= '0;
        end
        else if (byte_en)
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (byte_en && store_we[i])
                store_reg[i] <= store_wdata;
        end
    end

endmodule

// ===== rtl/core/motor_command_frame_parser_core.sv =====
// Motor command frame parser top level: handshake, config registers,
// idle and error budget counters, result register. Uses mcfp_pkg, mcfp_frame.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | kind, data_byte
//  out      | out_valid / out_ready| result_kind, value_a..value_d, move_code
//  cfg      | cfg_write_en         | cfg_index, cfg_data
//
// One transaction per cycle on the input; a result appears in the cycle after
// the input transaction that causes it, from the single result register.
// in_ready drops only while a result is held and out_ready is low.
// Reset is asynchronous, active low; config registers return to 100 / 1 / 20.
`timescale 1ns / 1ps

module motor_command_frame_parser_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [7:0]               data_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               result_kind,
    output logic signed [mcfp_pkg::VAL_W-1:0] value_a,
    output logic signed [mcfp_pkg::VAL_W-1:0] value_b,
    output logic signed [mcfp_pkg::VAL_W-1:0] value_c,
    output logic signed [mcfp_pkg::VAL_W-1:0] value_d,
    output logic [7:0]               move_code,
    input  logic                     cfg_write_en,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data
);
    import mcfp_pkg::*;

    logic        accept;
    logic        byte_en;
    frame_evt_t  evt;

    logic [15:0] idle_limit_reg;
    logic        stop_en_reg;
    logic [7:0]  err_budget_reg;
    logic [15:0] idle_count_reg, idle_count_next;
    logic [7:0]  error_left_reg, error_left_next;

    logic        out_valid_reg;
    res_kind_t   kind_reg, kind_next;
    val_t        a_reg, b_reg, c_reg, d_reg;
    val_t        a_next, b_next, c_next, d_next;
    logic [7:0]  code_reg, code_next;
    logic        res_valid;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign byte_en  = accept && !kind;

    mcfp_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .evt       (evt)
    );

    always_comb
    begin
        idle_count_next = idle_count_reg;
        error_left_next = error_left_reg;
        res_valid = 1'b0;
        kind_next = RK_STOP;
        a_next    = '0;
        b_next    = '0;
        c_next    = '0;
        d_next    = '0;
        code_next = '0;
        if (kind)
        begin
            error_left_next = err_budget_reg;
            if (stop_en_reg)
            begin
                if (idle_count_reg == 16'd0)
                    res_valid = 1'b1;
                else
                    idle_count_next = idle_count_reg - 16'd1;
            end
        end
        else
        begin
            idle_count_next = idle_limit_reg;
            if (evt.reload)
                error_left_next = err_budget_reg;
            if (evt.stray)
            begin
                if (error_left_reg != 8'd0)
                    error_left_next = error_left_reg - 8'd1;
                else
                    res_valid = 1'b1;
            end
            if (evt.result_valid)
            begin
                res_valid = 1'b1;
                kind_next = evt.result_kind;
                a_next    = evt.value_a;
                b_next    = evt.value_b;
                c_next    = evt.value_c;
                d_next    = evt.value_d;
                code_next = evt.move_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
            stop_en_reg    <= STOP_EN_RST;
            err_budget_reg <= ERR_BUDGET_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data;
                CFG_STOP_EN:    stop_en_reg    <= cfg_data[0];
                CFG_ERR_BUDGET: err_budget_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_count_reg <= IDLE_LIMIT_RST;
            error_left_reg <= ERR_BUDGET_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                idle_count_reg <= idle_count_next;
                error_left_reg <= error_left_next;
            end
            if (accept && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg <= kind_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
            code_reg <= code_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign value_a     = a_reg;
    assign value_b     = b_reg;
    assign value_c     = c_reg;
    assign value_d     = d_reg;
    assign move_code   = code_reg;

endmodule

// ===== rtl/core/mcfp_checker.sv =====
// Port-level checks for the motor command frame parser, bound to the top level.
// Depends on mcfp_pkg.
`timescale 1ns / 1ps

module mcfp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    result_kind,
    input logic signed [mcfp_pkg::VAL_W-1:0] value_a,
    input logic signed [mcfp_pkg::VAL_W-1:0] value_b,
    input logic signed [mcfp_pkg::VAL_W-1:0] value_c,
    input logic signed [mcfp_pkg::VAL_W-1:0] value_d,
    input logic [7:0]                    move_code
);
    import mcfp_pkg::*;

    // held result blocks new input transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("in_ready high while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(value_a) && $stable(value_b) && $stable(move_code))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_STOP) |->
            value_a == '0 && value_b == '0 && value_c == '0
            && value_d == '0 && move_code == '0)
        else $error("stop result carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_ANGLE || result_kind == RK_MOVE) |->
            value_c == '0 && value_d == '0)
        else $error("unused wheel fields not zero");

endmodule

bind motor_command_frame_parser_core mcfp_checker u_mcfp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .value_a     (value_a),
    .value_b     (value_b),
    .value_c     (value_c),
    .value_d     (value_d),
    .move_code   (move_code)
);
